// File: hw/rtl/cml_pkg.sv
// Package with the request, result and job types and the calendar tables.
package cml_pkg;

    // Month numbers.
    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_MAR = 4'd3;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_MAY = 4'd5;
    localparam logic [3:0] MON_JUN = 4'd6;
    localparam logic [3:0] MON_JUL = 4'd7;
    localparam logic [3:0] MON_AUG = 4'd8;
    localparam logic [3:0] MON_SEP = 4'd9;
    localparam logic [3:0] MON_OCT = 4'd10;
    localparam logic [3:0] MON_NOV = 4'd11;
    localparam logic [3:0] MON_DEC = 4'd12;

    // Last weekday of a row (Saturday).
    localparam logic [2:0] WD_SAT = 3'd6;

    // Reciprocal of 100 for values below 43699: x / 100 == (x * 5243) >> 19.
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    // Depth of the job queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [3:0]  month;
        logic [13:0] year;
    } t_req;

    typedef struct packed {
        logic [4:0] day_number;
        logic [2:0] weekday;
        logic       ends_week;
        logic [4:0] month_length;
        logic       bad_month;
        logic       last;
    } t_res;

    // One classified month, ready to be laid out.
    typedef struct packed {
        logic       bad_month;
        logic [4:0] month_length;
        logic [2:0] start_wd;
    } t_job;

    // Transfer from the front into the queue.
    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    // Head of the queue as seen by the back part.
    typedef struct packed {
        logic avail;
        t_job job;
    } t_head;

    // Days in a valid month.
    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] d;
        d = 5'd31;
        case (month)
            MON_FEB: d = leap ? 5'd29 : 5'd28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

    // Zeller month term (13 * (m + 1)) / 5 for the shifted month 3..14.
    function automatic logic [5:0] zeller_month(input logic [3:0] mm);
        logic [5:0] t;
        t = 6'd0;
        case (mm)
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            4'd13:   t = 6'd36;
            4'd14:   t = 6'd39;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

    // Remainder modulo 7 of an 11-bit value; folds octal digits since 8 is 1 mod 7.
    function automatic logic [2:0] mod7(input logic [10:0] a);
        logic [4:0] f;
        logic [3:0] g;
        f = 5'(a[2:0]) + 5'(a[5:3]) + 5'(a[8:6]) + 5'(a[10:9]);
        g = 4'(f[2:0]) + 4'(f[4:3]);
        if (g >= 4'd7) begin
            g = g - 4'd7;
        end
        return g[2:0];
    endfunction

endpackage

// File: hw/rtl/cml_front.sv
// Front part: takes a request, classifies the month and finds its length and first weekday.
module cml_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  cml_pkg::t_req i_req,
    input  logic          i_queue_full,
    output cml_pkg::t_push o_push
);
    import cml_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV0 = 2'd1;
    localparam logic [1:0] F_DIV1 = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]  r_state, n_state;
    t_req        r_req;
    logic [14:0] r_yy;
    logic [3:0]  r_mm;
    logic [7:0]  r_j0;
    logic [7:0]  r_j;
    logic [4:0]  r_len;
    logic        r_bad;

    logic        accept;
    logic        bad;
    logic [26:0] prod0;
    logic [27:0] prod1;
    logic [6:0]  k0;
    logic        leap;
    logic [6:0]  k;
    logic [10:0] h_sum;

    assign busy   = (r_state != F_IDLE) || i_queue_full;
    assign accept = start && !busy;
    assign bad    = (i_req.month < MON_JAN) || (i_req.month > MON_DEC);

    // Control sequence: one request goes through the two divide steps, then into the queue.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (accept) n_state = F_DIV0;
            F_DIV0: n_state = F_DIV1;
            F_DIV1: n_state = F_PUSH;
            F_PUSH: if (!i_queue_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the request and its validity.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
            r_bad <= bad;
        end
    end

    // Step one: year / 100 for the leap rule; shift January and February to the prior year.
    assign prod0 = 27'(r_req.year) * 27'(RECIP_100);
    always_ff @(posedge i_clk) begin
        if (r_state == F_DIV0) begin
            r_j0 <= 8'(prod0 >> RECIP_SHIFT);
            if (r_req.month < MON_MAR) begin
                r_mm <= r_req.month + 4'd12;
                r_yy <= 15'(r_req.year) + 15'd399;
            end else begin
                r_mm <= r_req.month;
                r_yy <= 15'(r_req.year) + 15'd400;
            end
        end
    end

    // Step two: shifted year / 100 for Zeller's congruence, and the month length.
    assign prod1 = 28'(r_yy) * 28'(RECIP_100);
    assign k0    = 7'(15'(r_req.year) - 15'(r_j0) * 15'd100);
    assign leap  = (r_req.year[1:0] == 2'd0) && ((k0 != 7'd0) || (r_j0[1:0] == 2'd0));
    always_ff @(posedge i_clk) begin
        if (r_state == F_DIV1) begin
            r_j   <= 8'(prod1 >> RECIP_SHIFT);
            r_len <= month_days(r_req.month, leap);
        end
    end

    // Weekday of day 1: Zeller's h, moved so that Sunday is 0 (plus 6, mod 7).
    assign k     = 7'(r_yy - 15'(r_j) * 15'd100);
    assign h_sum = 11'd7 + 11'(zeller_month(r_mm)) + 11'(k) + 11'(k[6:2])
                 + 11'(r_j[7:2]) + 11'(r_j) * 11'd5;

    always_comb begin
        o_push.valid            = (r_state == F_PUSH) && !i_queue_full;
        o_push.job.bad_month    = r_bad;
        o_push.job.month_length = r_bad ? 5'd0 : r_len;
        o_push.job.start_wd     = r_bad ? 3'd0 : mod7(h_sum);
    end

endmodule

// File: hw/rtl/cml_queue.sv
// Short job queue between the front and back parts.
module cml_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cml_pkg::t_push i_push,
    input  logic           i_pop,
    output logic           o_full,
    output cml_pkg::t_head o_head
);
    import cml_pkg::*;

    t_job                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full      = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_head.avail = (r_count != '0);
    assign o_head.job   = r_mem[r_rd_ptr];
    assign do_push     = i_push.valid && !o_full;
    assign do_pop      = i_pop && o_head.avail;

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/cml_back.sv
// Back part: walks through the days of a queued month, one result per cycle within a month.
module cml_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cml_pkg::t_head i_head,
    output logic           o_pop,
    output logic           o_strobe,
    output cml_pkg::t_res  o_res
);
    import cml_pkg::*;

    logic       r_active;
    logic [4:0] r_day;
    logic [2:0] r_wd;
    logic [4:0] r_len;
    logic       r_bad;
    logic       r_strobe;
    t_res       r_res;

    logic       is_last;

    assign o_pop    = !r_active && i_head.avail;
    assign is_last  = r_bad || (r_day == r_len);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    // Day counter control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_active;
            if (o_pop) begin
                r_active <= 1'b1;
            end else if (r_active && is_last) begin
                r_active <= 1'b0;
            end
        end
    end

    // Day and weekday counters; an invalid month gives one all-zero day.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bad <= i_head.job.bad_month;
            r_len <= i_head.job.month_length;
            r_wd  <= i_head.job.start_wd;
            r_day <= i_head.job.bad_month ? 5'd0 : 5'd1;
        end else if (r_active) begin
            r_day <= r_day + 5'd1;
            r_wd  <= (r_wd == WD_SAT) ? 3'd0 : r_wd + 3'd1;
        end
    end

    // Registered result for the current day.
    always_ff @(posedge i_clk) begin
        if (r_active) begin
            r_res.day_number   <= r_day;
            r_res.weekday      <= r_wd;
            r_res.ends_week    <= !r_bad && (r_wd == WD_SAT);
            r_res.month_length <= r_len;
            r_res.bad_month    <= r_bad;
            r_res.last         <= is_last;
        end
    end

endmodule

// File: hw/rtl/calendar_month_layout.sv
// Top level of the month layout block: front classifier, job queue and day sequencer.
// A request (month, year) is taken when start is high and busy is low. After that transfer
// the front part works through two reciprocal multiplies by 1/100, then the weekday sum,
// and places the month in a two-entry queue; it takes no new request before that month is
// in the queue, and busy is high while it works and while the queue is full.
// The back part then gives one result per cycle on o_res, marked by o_strobe, for day 1
// through the last day; the final result carries last. A month outside 1 to 12 gives a
// single result with bad_month and last set. With the back part idle, the first result
// of a month follows its request through the front steps, the queue and the back part's
// registers. The back part loads a month and then gives one result per day, taking the
// next month only after the last day, and that sets the sustained rate; results cannot be
// held off, so the receiver must take each one in the cycle it appears.
module calendar_month_layout (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  cml_pkg::t_req i_req,
    output logic          o_strobe,
    output cml_pkg::t_res o_res
);
    import cml_pkg::*;

    t_push push;
    t_head head;
    logic  queue_full;
    logic  pop;

    // Request intake and classification.
    cml_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req        (i_req),
        .i_queue_full (queue_full),
        .o_push       (push)
    );

    // Queue of classified months.
    cml_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_head  (head)
    );

    // Day-by-day result generation.
    cml_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

`ifndef SYNTHESIS
    // The front never offers a month to a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid |-> !queue_full)
        else $error("month pushed into full queue");

    // Days of one month come out in consecutive cycles.
    a_days_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_res.last)
        |=> (o_strobe && o_res.day_number == $past(o_res.day_number) + 5'd1))
        else $error("gap or skip inside a month");

    // An invalid month is a single closing result.
    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.bad_month) |-> (o_res.last && o_res.day_number == 5'd0))
        else $error("bad month result malformed");

    // The last day of a valid month equals its length.
    a_last_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_res.bad_month && o_res.last)
        |-> (o_res.day_number == o_res.month_length))
        else $error("last flag off the final day");

    // An accepted request keeps busy high in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after accepting a request");
`endif

endmodule

// File: test/tb_calendar_month_layout.sv
// Self-checking testbench for calendar_month_layout: directed and random requests against a day predictor.
module tb_calendar_month_layout;
    timeunit 1ns;
    timeprecision 1ps;

    import cml_pkg::*;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    t_req  i_req = '0;
    logic  o_strobe;
    t_res  o_res;

    // Requests waiting to be sent and day rows waiting to come back.
    t_req  pending_months[$];
    t_res  days_due[$];

    int    mismatch_count = 0;
    int    idle_left = 0;
    int    calm_left = 0;
    bit    calm = 1'b0;

    calendar_month_layout dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    always #1 i_clk = ~i_clk;

    // Weekday of the first of month m in year y, 0 is Sunday, by Zeller's congruence.
    // Four hundred years are added first so January and February of year 0 stay positive.
    function automatic int first_weekday_of(input int m, input int y);
        int yy;
        int mm;
        int k;
        int j;
        int h;
        yy = y + 400;
        mm = m;
        if (mm < 3) begin
            mm = mm + 12;
            yy = yy - 1;
        end
        k = yy % 100;
        j = yy / 100;
        h = (1 + (13 * (mm + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
        return (h + 6) % 7;
    endfunction

    // Append the day rows that one request should produce.
    function automatic void lay_out_month(input t_req rq);
        t_res row;
        int   len;
        int   wd0;
        int   wd;
        int   y;
        bit   leap;
        row = '0;
        if (rq.month < MON_JAN || rq.month > MON_DEC) begin
            row.bad_month = 1'b1;
            row.last = 1'b1;
            days_due.push_back(row);
            return;
        end
        y = int'(rq.year);
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        case (rq.month)
            MON_FEB: len = leap ? 29 : 28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 30;
            default: len = 31;
        endcase
        wd0 = first_weekday_of(int'(rq.month), y);
        for (int d = 1; d <= len; d++) begin
            wd = (wd0 + d - 1) % 7;
            row.day_number = 5'(d);
            row.weekday = 3'(wd);
            row.ends_week = (3'(wd) == WD_SAT);
            row.month_length = 5'(len);
            row.bad_month = 1'b0;
            row.last = (d == len);
            days_due.push_back(row);
        end
    endfunction

    // Idle cycles before the next request; stretches of back-to-back requests come in between.
    function automatic int next_gap();
        int r;
        if (calm_left == 0) begin
            calm_left = $urandom_range(6, 20);
            calm = ($urandom_range(0, 3) == 0);
        end
        calm_left--;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Driver: records each accepted transfer and presents the next request.
    always @(posedge i_clk) begin
        logic taken;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            taken = start && !busy;
            if (taken) begin
                lay_out_month(i_req);
                void'(pending_months.pop_front());
                idle_left = next_gap();
            end
            if (!start || taken) begin
                if (idle_left > 0) begin
                    idle_left--;
                    start <= 1'b0;
                end else if (pending_months.size() != 0) begin
                    start <= 1'b1;
                    i_req <= pending_months[0];
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: each strobed result is checked against the oldest expected day row.
    always @(posedge i_clk) begin
        t_res want;
        logic wrong;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (days_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("Unexpected result: day %0d wd %0d sat %0b len %0d bad %0b last %0b",
                             o_res.day_number, o_res.weekday, o_res.ends_week,
                             o_res.month_length, o_res.bad_month, o_res.last);
                end
            end else begin
                want = days_due.pop_front();
                wrong = (o_strobe !== 1'b1)
                     || (o_res.day_number !== want.day_number)
                     || (o_res.weekday !== want.weekday)
                     || (o_res.ends_week !== want.ends_week)
                     || (o_res.month_length !== want.month_length)
                     || (o_res.bad_month !== want.bad_month)
                     || (o_res.last !== want.last);
                if (wrong) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display({"Mismatch: expected day %0d wd %0d sat %0b len %0d",
                                  " bad %0b last %0b"},
                                 want.day_number, want.weekday, want.ends_week,
                                 want.month_length, want.bad_month, want.last);
                        $display({"          actual   day %0d wd %0d sat %0b len %0d",
                                  " bad %0b last %0b"},
                                 o_res.day_number, o_res.weekday, o_res.ends_week,
                                 o_res.month_length, o_res.bad_month, o_res.last);
                    end
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        t_req rq;
        int   r;
        int   pick;

        // Invalid months, with extreme years.
        pending_months.push_back('{month: 4'd0, year: 14'd0});
        pending_months.push_back('{month: MON_DEC + 4'd1, year: 14'd16383});
        pending_months.push_back('{month: MON_DEC + 4'd2, year: 14'd1});
        pending_months.push_back('{month: MON_DEC + 4'd3, year: 14'd9999});

        // Every month of a leap year.
        for (int m = 1; m <= 12; m++) begin
            pending_months.push_back('{month: 4'(m), year: 14'd2024});
        end

        // February across the leap-year rule, then months around year zero, year 9999 and years past it.
        pending_months.push_back('{month: MON_FEB, year: 14'd2000});
        pending_months.push_back('{month: MON_FEB, year: 14'd1900});
        pending_months.push_back('{month: MON_FEB, year: 14'd2023});
        pending_months.push_back('{month: MON_JAN, year: 14'd0});
        pending_months.push_back('{month: MON_FEB, year: 14'd0});
        pending_months.push_back('{month: MON_MAR, year: 14'd0});
        pending_months.push_back('{month: MON_DEC, year: 14'd9999});
        pending_months.push_back('{month: MON_FEB, year: 14'd16000});
        pending_months.push_back('{month: MON_JAN, year: 14'd16383});

        // Random requests: mostly valid months, years across the whole field.
        for (int i = 0; i < 85; i++) begin
            r = $urandom_range(0, 99);
            if (r < 85) begin
                rq.month = 4'($urandom_range(1, 12));
            end else begin
                pick = $urandom_range(0, 3);
                rq.month = (pick == 0) ? 4'd0 : MON_DEC + 4'(pick);
            end
            r = $urandom_range(0, 99);
            if (r < 65) begin
                rq.year = 14'($urandom_range(1, 9999));
            end else if (r < 88) begin
                rq.year = 14'($urandom_range(0, 16383));
            end else begin
                rq.year = 14'($urandom_range(0, 163) * 100);
            end
            pending_months.push_back(rq);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_months.size() != 0 || start) begin
            @(posedge i_clk);
        end
        while (days_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog against a hung block.
    initial begin
        #500000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: calendar_month_layout.f
hw/rtl/cml_pkg.sv
hw/rtl/cml_front.sv
hw/rtl/cml_queue.sv
hw/rtl/cml_back.sv
hw/rtl/calendar_month_layout.sv
test/tb_calendar_month_layout.sv
